/* hdl/svpwm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package svpwm_pkg;

    localparam int SINE_FRAC_BITS_DEF = 16;
    localparam int PERIOD_BITS_DEF    = 16;
    localparam int FIELD_W            = 16;
    localparam int SECTOR_W           = 3;
    localparam int DEPTH_FRAC_BITS    = 15;
    localparam logic [16:0] FULL_TURN = 17'd36000;
    localparam logic [15:0] DEPTH_ONE = 16'd32768;
    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam int SECTOR_SPAN        = 6000;
    localparam int NUM_SECTORS        = 6;
    localparam int SINE_TABLE_DEPTH   = 6001;

    // sector codes
    localparam logic [SECTOR_W-1:0] SECTOR_0 = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_1 = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_2 = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_3 = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_4 = 3'd4;
    localparam logic [SECTOR_W-1:0] SECTOR_5 = 3'd5;

    // per-item payload travelling along the chain
    typedef struct packed {
        logic [15:0]         angle;
        logic [15:0]         depth;
        logic [SECTOR_W-1:0] sector;
    } svpwm_item_t;

    // sine in Q0.frac of hd hundredths of a degree, rounded to nearest
    function automatic logic [24:0] sine_q(input int hd, input int frac);
        real x;
        real s;
        x = real'(hd) * 3.14159265358979323846 / 18000.0;
        s = $sin(x) * (2.0 ** frac);
        return 25'($rtoi(s + 0.5));
    endfunction

endpackage
`default_nettype wire

/* hdl/svpwm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// one cell of the chain: takes the angle apart one sector step at a time
module svpwm_cell
    import svpwm_pkg::*;
#(
    parameter int STEP = 0
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire logic        vld_in,
    input  wire svpwm_item_t item_in,
    output logic             vld_out,
    output svpwm_item_t      item_out
);

    localparam logic [15:0] SPAN = 16'(SECTOR_SPAN);

    logic        vld_reg;
    svpwm_item_t item_reg;
    svpwm_item_t item_next;

    always_comb
    begin
        item_next = item_in;
        if (item_in.angle >= SPAN)
        begin
            item_next.angle  = item_in.angle - SPAN;
            item_next.sector = item_in.sector + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            item_reg <= item_next;
    end

    assign vld_out  = vld_reg;
    assign item_out = item_reg;

    // a cell never leaves more than one span after its step count
    property p_sector_bound;
        @(posedge clk) disable iff (!rst_n)
        vld_reg |-> (item_reg.sector <= 3'(STEP + 1));
    endproperty
    a_sector_bound: assert property (p_sector_bound) else $error("sector past cell step");

    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        !$past(adv) |-> $stable(vld_reg);
    endproperty
    a_hold: assert property (p_hold) else $error("cell moved without advance");

    property p_theta_range;
        @(posedge clk) disable iff (!rst_n)
        (vld_reg && STEP == NUM_SECTORS - 1) |-> (item_reg.angle < SPAN);
    endproperty
    a_theta_range: assert property (p_theta_range) else $error("theta out of sector");

endmodule
`default_nettype wire

/* hdl/svpwm_compare_values.sv */
`timescale 1ns / 1ps
`default_nettype none
// pipeline stages from input transfer to result valid: 1 wrap/saturate, 6 sector
//   cells, 1 sine lookup, 1 multiply, 1 scale, 1 compare assembly
// throughput: one transfer per cycle; the whole pipeline advances whenever the output
//   register is empty or is being taken, so one item per cycle is sustained
// reset: rst_n asynchronous, clears all valid flags and sets the period register to 1000
module svpwm_compare_values
    import svpwm_pkg::*;
#(
    parameter int SINE_FRAC_BITS = SINE_FRAC_BITS_DEF,
    parameter int PERIOD_BITS    = PERIOD_BITS_DEF
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [15:0]         cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [15:0]         ref_angle,
    input  wire logic [15:0]         depth,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [FIELD_W-1:0]       cmp_a,
    output logic [FIELD_W-1:0]       cmp_b,
    output logic [FIELD_W-1:0]       cmp_c,
    output logic [SECTOR_W-1:0]      sector
);

    localparam int SW    = SINE_FRAC_BITS + 1;          // sine incl. the 1.0 code
    localparam int PW    = PERIOD_BITS;
    localparam int PDW   = PW + 17;                     // period * depth
    localparam int PRODW = PDW + SW;
    localparam int SHIFT = DEPTH_FRAC_BITS + SINE_FRAC_BITS;
    localparam int TW    = PW + 1;                      // t1, t2 each at most ~period

    // whole pipe advances together; stall only when the output is held
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // period register
    logic [15:0] period_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else if (cfg_we)
            period_reg <= cfg_wdata;
    end

    logic [PW-1:0] period;
    assign period = PW'(period_reg & 16'((17'd1 << PW) - 17'd1));

    // entry stage: wrap angle, saturate depth
    logic        v0_reg;
    svpwm_item_t it0_reg;
    svpwm_item_t it0_next;
    always_comb
    begin
        it0_next.angle  = ({1'b0, ref_angle} >= FULL_TURN) ?
                          16'({1'b0, ref_angle} - FULL_TURN) : ref_angle;
        it0_next.depth  = (depth > DEPTH_ONE) ? DEPTH_ONE : depth;
        it0_next.sector = SECTOR_0;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            it0_reg <= it0_next;
    end

    // chain of sector cells, each strips one span off the angle when the angle is at least one span
    logic        cv [NUM_SECTORS+1];
    svpwm_item_t ci [NUM_SECTORS+1];
    assign cv[0] = v0_reg;
    assign ci[0] = it0_reg;
    for (genvar g = 0; g < NUM_SECTORS; g++)
    begin : g_cell
        svpwm_cell #(.STEP(g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .vld_in   (cv[g]),
            .item_in  (ci[g]),
            .vld_out  (cv[g+1]),
            .item_out (ci[g+1])
        );
    end

    // sine table, 0..60 degrees in hundredths
    logic [SW-1:0] sine_rom [SINE_TABLE_DEPTH];
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++)
    begin : g_rom
        assign sine_rom[k] = SW'(sine_q(k, SINE_FRAC_BITS));
    end

    // sine lookup and period * depth
    logic                v1_reg;
    logic [SW-1:0]       s1_reg, s2_reg;
    logic [PDW-1:0]      pd_reg;
    logic [SECTOR_W-1:0] sec1_reg;
    logic [12:0]         theta;
    assign theta = ci[NUM_SECTORS].angle[12:0];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= cv[NUM_SECTORS];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= sine_rom[13'(SECTOR_SPAN) - theta];
            s2_reg   <= sine_rom[theta];
            pd_reg   <= PDW'(period) * PDW'(ci[NUM_SECTORS].depth);
            sec1_reg <= ci[NUM_SECTORS].sector;
        end
    end

    // scale by sine
    logic                v2_reg;
    logic [PRODW-1:0]    p1_reg, p2_reg;
    logic [SECTOR_W-1:0] sec2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg   <= PRODW'(pd_reg) * PRODW'(s1_reg);
            p2_reg   <= PRODW'(pd_reg) * PRODW'(s2_reg);
            sec2_reg <= sec1_reg;
        end
    end

    // t1, t2, half of t0
    logic                v3_reg;
    logic [TW-1:0]       t1_reg, t2_reg, h_reg;
    logic [SECTOR_W-1:0] sec3_reg;
    logic [TW-1:0]       t1_next, t2_next;
    logic [TW:0]         tsum;
    assign t1_next = TW'(p1_reg >> SHIFT);
    assign t2_next = TW'(p2_reg >> SHIFT);
    assign tsum    = {1'b0, t1_next} + {1'b0, t2_next};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            h_reg    <= (tsum > (TW+1)'(period)) ? '0 : TW'(((TW+1)'(period) - tsum) >> 1);
            sec3_reg <= sec2_reg;
        end
    end

    // compare assembly into the output register
    logic [TW+1:0]      ha, hb, hc;
    logic [FIELD_W-1:0] a_next, b_next, c_next;
    assign ha = (TW+2)'(h_reg);
    assign hb = (TW+2)'(h_reg) + (TW+2)'(t1_reg);
    assign hc = (TW+2)'(h_reg) + (TW+2)'(t2_reg);
    logic [TW+1:0] hall;
    assign hall = hb + (TW+2)'(t2_reg);

    always_comb
    begin
        unique case (sec3_reg)
            SECTOR_0: begin a_next = FIELD_W'(ha);   b_next = FIELD_W'(hb);   c_next = FIELD_W'(hall); end
            SECTOR_1: begin a_next = FIELD_W'(hc);   b_next = FIELD_W'(ha);   c_next = FIELD_W'(hall); end
            SECTOR_2: begin a_next = FIELD_W'(hall); b_next = FIELD_W'(ha);   c_next = FIELD_W'(hb);   end
            SECTOR_3: begin a_next = FIELD_W'(hall); b_next = FIELD_W'(hc);   c_next = FIELD_W'(ha);   end
            SECTOR_4: begin a_next = FIELD_W'(hb);   b_next = FIELD_W'(hall); c_next = FIELD_W'(ha);   end
            default:  begin a_next = FIELD_W'(ha);   b_next = FIELD_W'(hall); c_next = FIELD_W'(hc);   end
        endcase
    end

    logic out_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmp_a  <= a_next;
            cmp_b  <= b_next;
            cmp_c  <= c_next;
            sector <= sec3_reg;
        end
    end
    assign out_valid = out_valid_reg;

    // a held result is never overwritten while the far side stalls
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(cmp_a) && $stable(sector));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result lost under stall");

    property p_sector_range;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (sector <= SECTOR_5);
    endproperty
    a_sector_range: assert property (p_sector_range) else $error("sector out of range");

    property p_stall_link;
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall);
    endproperty
    a_stall_link: assert property (p_stall_link) else $error("input stalled without cause");

endmodule
`default_nettype wire
